[rtl/tcb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the text cell buffer blitter.
// No dependencies; imported by front, back, top and bench.
package tcb_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMNS);
	localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);

	localparam logic [7:0] SPACE_CODE = 8'h20;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_ADDR_W = 4;

	// input mode codes
	localparam logic [2:0] MODE_CLEAR = 3'd0;
	localparam logic [2:0] MODE_PUT   = 3'd1;
	localparam logic [2:0] MODE_BLIT  = 3'd2;
	localparam logic [2:0] MODE_READ  = 3'd3;
	localparam logic [2:0] MODE_TICK  = 3'd4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_BLINK_PERIOD = 2'd0;
	localparam logic [1:0] REG_LIT_COLOR    = 2'd1;
	localparam logic [1:0] REG_DARK_COLOR   = 2'd2;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PUT,
		OP_BLIT,
		OP_READ,
		OP_TICK
	} tcb_op_t;

	typedef struct packed {
		tcb_op_t           op;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col_hi;
		logic [ROW_W-1:0]  row_hi;
		logic [7:0]        letter;
		logic [7:0]        color;
		logic [7:0]        bits;
		logic              on_screen;
	} tcb_cmd_t;

	typedef struct packed {
		logic     valid;
		tcb_cmd_t cmd;
	} tcb_head_t;

	typedef struct packed {
		logic pop;
		logic init_busy;
	} tcb_back_st_t;

	typedef struct packed {
		logic [7:0] blink_period;
		logic [7:0] lit_color;
		logic [7:0] dark_color;
	} tcb_cfg_t;

endpackage

[rtl/tcb_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command words and read response words.
// Standalone; field widths follow the block's item layout.
interface tcb_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [6:0] col;
	logic [4:0] row;
	logic [6:0] col_end;
	logic [4:0] row_end;
	logic [7:0] letter;
	logic [7:0] color;
	logic [7:0] bitmap_byte;
	logic [3:0] rows;

	modport source (output valid, mode, col, row, col_end, row_end, letter, color,
		bitmap_byte, rows, input ready);
	modport sink (input valid, mode, col, row, col_end, row_end, letter, color,
		bitmap_byte, rows, output ready);
endinterface

interface tcb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] shown_letter;
	logic [3:0] fore;
	logic [2:0] back;
	logic       blinking;
	logic [6:0] pair_index;

	modport source (output valid, shown_letter, fore, back, blinking, pair_index,
		input ready);
	modport sink (input valid, shown_letter, fore, back, blinking, pair_index,
		output ready);
endinterface

[rtl/tcb_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data, read-first.
// No dependencies.
module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/tcb_front.sv]
`timescale 1ns / 1ps
// Front end: accepts command words, clips and classifies them, queues kept ones.
// Depends on tcb_pkg and tcb_cmd_if.
module tcb_front import tcb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tcb_cmd_if.sink       cmd,
	input  tcb_back_st_t  back_st,
	output tcb_head_t     head
);

	tcb_cmd_t         q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	tcb_cmd_t   cls;
	logic       keep;
	logic       push;
	logic       pop;
	logic [3:0] blit_n8;
	logic [ROW_W-1:0] rows_left;
	logic [ROW_W-1:0] blit_n;

	assign cmd.ready = !back_st.init_busy && (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop       = back_st.pop;
	assign push      = cmd.valid && cmd.ready && keep;

	assign head.valid = (count_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];

	assign blit_n8   = (cmd.rows > 4'd8) ? 4'd8 : cmd.rows;
	assign rows_left = ROW_LIMIT - cmd.row;
	assign blit_n    = ({1'b0, blit_n8} > rows_left) ? rows_left : {1'b0, blit_n8};

	always_comb begin
		cls.op        = OP_TICK;
		cls.col       = cmd.col;
		cls.row       = cmd.row;
		cls.col_hi    = cmd.col;
		cls.row_hi    = cmd.row;
		cls.letter    = cmd.letter;
		cls.color     = cmd.color;
		cls.bits      = cmd.bitmap_byte;
		cls.on_screen = (cmd.col < COL_LIMIT) && (cmd.row < ROW_LIMIT);
		keep          = 1'b0;
		unique case (cmd.mode)
			MODE_CLEAR: begin
				cls.op     = OP_CLEAR;
				cls.col_hi = (cmd.col_end > COL_LIMIT) ? COL_LIMIT : cmd.col_end;
				cls.row_hi = (cmd.row_end > ROW_LIMIT) ? ROW_LIMIT : cmd.row_end;
				keep       = (cmd.col < cls.col_hi) && (cmd.row < cls.row_hi);
			end
			MODE_PUT: begin
				cls.op = OP_PUT;
				keep   = cls.on_screen;
			end
			MODE_BLIT: begin
				cls.op     = OP_BLIT;
				cls.row_hi = cmd.row + blit_n;
				keep       = cls.on_screen && (blit_n != '0);
			end
			MODE_READ: begin
				cls.op = OP_READ;
				keep   = 1'b1;
			end
			MODE_TICK: begin
				cls.op = OP_TICK;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				q_mem_q[wr_ptr_q] <= cls;
				wr_ptr_q          <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/tcb_back.sv]
`timescale 1ns / 1ps
// Back end: sequencer that walks cells in the letter and colour RAMs, keeps
// the blink phase and holds the response register. Depends on tcb_pkg,
// tcb_ram and tcb_rsp_if.
module tcb_back import tcb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  tcb_head_t     head,
	input  tcb_cfg_t      cfg,
	output tcb_back_st_t  back_st,
	tcb_rsp_if.source     rsp
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_RECT,
		S_BLIT,
		S_PUT_WR,
		S_READ_RSP
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] init_addr_q;
	tcb_cmd_t          cmd_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [7:0]        blink_count_q;
	logic              blink_on_q;
	logic              rsp_valid_q;
	logic [7:0]        rsp_letter_q;
	logic [7:0]        rsp_color_q;

	logic [COL_W-1:0]  sel_col;
	logic [ROW_W-1:0]  sel_row;
	logic [ADDR_W-1:0] cell_addr;
	logic [ADDR_W-1:0] ram_addr;
	logic              let_we, col_we;
	logic [7:0]        let_wd, col_wd, let_rd, col_rd;
	logic              pop;
	logic              out_free;
	logic [7:0]        period_eff;
	logic [8:0]        count_next;
	logic              blink_wrap;
	logic [7:0]        rd_letter, rd_color;

	assign out_free          = !rsp_valid_q || rsp.ready;
	assign back_st.pop       = pop;
	assign back_st.init_busy = (state_q == S_INIT);

	assign period_eff = (cfg.blink_period == 8'd0) ? 8'd1 : cfg.blink_period;
	assign count_next = {1'b0, blink_count_q} + 9'd1;
	assign blink_wrap = (count_next >= {1'b0, period_eff});

	assign cell_addr = ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(COLUMNS)) + ADDR_W'(sel_col);
	assign ram_addr  = (state_q == S_INIT) ? init_addr_q : cell_addr;

	// off-screen reads see a cleared cell; blinking cells hide while the phase is off
	assign rd_color  = cmd_q.on_screen ? col_rd : 8'h00;
	assign rd_letter = (!cmd_q.on_screen || (rd_color[7] && !blink_on_q)) ? SPACE_CODE
		: let_rd;

	always_comb begin
		sel_col = cur_col_q;
		sel_row = cur_row_q;
		let_we  = 1'b0;
		col_we  = 1'b0;
		let_wd  = SPACE_CODE;
		col_wd  = 8'h00;
		pop     = 1'b0;
		unique case (state_q)
			S_INIT: begin
				let_we = 1'b1;
				col_we = 1'b1;
			end
			S_IDLE: begin
				sel_col = head.cmd.col;
				sel_row = head.cmd.row;
				if (head.valid) begin
					unique case (head.cmd.op)
						OP_READ: begin
							pop = out_free;
						end
						OP_PUT: begin
							pop    = 1'b1;
							let_we = 1'b1;
							let_wd = head.cmd.letter;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			S_RECT: begin
				let_we = 1'b1;
				col_we = 1'b1;
				col_wd = cmd_q.color;
			end
			S_BLIT: begin
				col_we = 1'b1;
				col_wd = cmd_q.bits[cur_row_q[2:0]] ? cfg.lit_color : cfg.dark_color;
			end
			S_PUT_WR: begin
				sel_col = cmd_q.col;
				sel_row = cmd_q.row;
				col_we  = 1'b1;
				col_wd  = col_rd | {4'h0, cmd_q.color[3:0]};
			end
			S_READ_RSP: begin
				sel_col = cmd_q.col;
				sel_row = cmd_q.row;
			end
			default: begin
				let_we = 1'b0;
			end
		endcase
	end

	tcb_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_letters (
		.clk   (clk),
		.we    (let_we),
		.addr  (ram_addr),
		.wdata (let_wd),
		.rdata (let_rd)
	);

	tcb_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_colors (
		.clk   (clk),
		.we    (col_we),
		.addr  (ram_addr),
		.wdata (col_wd),
		.rdata (col_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			init_addr_q   <= '0;
			blink_count_q <= 8'd0;
			blink_on_q    <= 1'b1;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (init_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= S_IDLE;
					end else begin
						init_addr_q <= init_addr_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (pop) begin
						cmd_q     <= head.cmd;
						cur_col_q <= head.cmd.col;
						cur_row_q <= head.cmd.row;
						unique case (head.cmd.op)
							OP_CLEAR: state_q <= S_RECT;
							OP_BLIT:  state_q <= S_BLIT;
							OP_PUT:   state_q <= S_PUT_WR;
							OP_READ:  state_q <= S_READ_RSP;
							default: begin
								if (blink_wrap) begin
									blink_count_q <= 8'd0;
									blink_on_q    <= !blink_on_q;
								end else begin
									blink_count_q <= count_next[7:0];
								end
							end
						endcase
					end
				end
				S_RECT: begin
					if (cur_col_q + COL_W'(1) == cmd_q.col_hi) begin
						cur_col_q <= cmd_q.col;
						if (cur_row_q + ROW_W'(1) == cmd_q.row_hi) begin
							state_q <= S_IDLE;
						end else begin
							cur_row_q <= cur_row_q + ROW_W'(1);
						end
					end else begin
						cur_col_q <= cur_col_q + COL_W'(1);
					end
				end
				S_BLIT: begin
					if (cur_row_q + ROW_W'(1) == cmd_q.row_hi) begin
						state_q <= S_IDLE;
					end else begin
						cur_row_q <= cur_row_q + ROW_W'(1);
					end
				end
				S_PUT_WR: begin
					state_q <= S_IDLE;
				end
				S_READ_RSP: begin
					rsp_valid_q  <= 1'b1;
					rsp_letter_q <= rd_letter;
					rsp_color_q  <= rd_color;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.shown_letter = rsp_letter_q;
	assign rsp.fore         = rsp_color_q[3:0];
	assign rsp.back         = rsp_color_q[6:4];
	assign rsp.blinking     = rsp_color_q[7];
	assign rsp.pair_index   = rsp_color_q[6:0];

endmodule

[rtl/text_cell_buffer_blitter.sv]
`timescale 1ns / 1ps
// Top level of the text cell buffer blitter: register port, front end, back end.
// Depends on tcb_pkg, tcb_if, tcb_front, tcb_back (and tcb_ram below it).
//
// A text-mode screen of COLUMNS x ROWS cells (80 x 25), each a letter byte and a
// colour byte (bit 7 blink, bits 6..4 background, bits 3..0 foreground), kept in
// two single-port RAMs. After reset the block runs a clearing pass that fills
// every cell with a space and colour 0; cmd.ready stays low for that time,
// register writes are taken as usual. A front end accepts one command word per
// cycle while cmd.ready is high (not clearing, queue not full) into a two-deep
// queue, clipping it to the screen and dropping words that would touch nothing
// (off-screen put or blit, empty rectangle, unused modes). The back end works
// one queued word at a time, bounded by the single RAM port: a frame tick is
// done as it is taken; put char reads the colour, then writes the ORed colour;
// read cell reads the RAMs, then loads the response register; blit and clear
// rectangle, once the word is taken, write one clipped row or cell per step.
// A read response sits in an output register, so the queue keeps filling while
// it waits to be taken. Registers: blink_period at 0x0, lit_color at 0x4,
// dark_color at 0x8; write them only while the block is idle.
module text_cell_buffer_blitter import tcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	tcb_cmd_if.sink               cmd,
	tcb_rsp_if.source             rsp
);

	logic [7:0]   blink_period_q;
	logic [7:0]   lit_color_q;
	logic [7:0]   dark_color_q;
	logic         cfg_wr;
	tcb_cfg_t     cfg;
	tcb_head_t    head;
	tcb_back_st_t back_st;

	// zero wait states: every access completes in its access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= 8'd15;
			lit_color_q    <= 8'h70;
			dark_color_q   <= 8'h00;
		end else if (cfg_wr) begin
			// decode on the word index; writes past the last register are dropped
			unique case (paddr[3:2])
				REG_BLINK_PERIOD: blink_period_q <= pwdata[7:0];
				REG_LIT_COLOR:    lit_color_q    <= pwdata[7:0];
				REG_DARK_COLOR:   dark_color_q   <= pwdata[7:0];
				default:          blink_period_q <= blink_period_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BLINK_PERIOD: prdata = {24'h0, blink_period_q};
			REG_LIT_COLOR:    prdata = {24'h0, lit_color_q};
			REG_DARK_COLOR:   prdata = {24'h0, dark_color_q};
			default:          prdata = 32'h0;
		endcase
	end

	assign cfg.blink_period = blink_period_q;
	assign cfg.lit_color    = lit_color_q;
	assign cfg.dark_color   = dark_color_q;

	// accept, clip and queue command words
	tcb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.back_st (back_st),
		.head    (head)
	);

	// carry out queued words against the cell RAMs and drive responses
	tcb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.cfg     (cfg),
		.back_st (back_st),
		.rsp     (rsp)
	);

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_cell_buffer_blitter: directed and random command words
// are checked against a screen predictor, and every read word is compared field by field.
// Depends on tcb_pkg, tcb_if and the RTL of the block.
module tb_top;
	import tcb_pkg::*;

	// Modes past the frame tick carry no meaning and must be dropped by the block.
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// Up to three full-screen clears can sit in the queue and the back end when the
	// last read word arrives; let them finish before touching a register.
	localparam int DRAIN_CYCLES = 3 * CELL_COUNT + 16;
	localparam int IDLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 300;

	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] col;
		logic [4:0] row;
		logic [6:0] col_end;
		logic [4:0] row_end;
		logic [7:0] letter;
		logic [7:0] color;
		logic [7:0] bitmap_byte;
		logic [3:0] rows;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] shown_letter;
		logic [3:0] fore;
		logic [2:0] back;
		logic       blinking;
		logic [6:0] pair_index;
	} read_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	tcb_cmd_if cmd ();
	tcb_rsp_if rsp ();

	text_cell_buffer_blitter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd),
		.rsp     (rsp)
	);

	// Screen predictor: its own copy of the cells, the blink state and the registers.
	logic [7:0] scr_letter [CELL_COUNT];
	logic [7:0] scr_color [CELL_COUNT];
	logic [7:0] tick_count;
	logic       phase_on;
	tcb_cfg_t   cfg_shadow;

	// Read words still owed by the block, oldest first.
	read_word_t pending_reads [$];

	int errors;
	bit steady;          // when set, neither side idles
	logic [6:0] hot_col;
	logic [4:0] hot_row;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic int cell_index(input int c, input int r);
		return r * COLUMNS + c;
	endfunction

	// Apply one accepted command word to the screen copy; a read cell queues
	// the word the block owes for it.
	function automatic void apply_word(input cmd_word_t w);
		int ce;
		int re;
		int n;
		int period;
		logic [7:0] lt;
		logic [7:0] cc;
		read_word_t rd;
		case (w.mode)
			MODE_CLEAR: begin
				// Clip the exclusive edges to the screen; an empty or inverted
				// rectangle falls out of the loops with nothing written.
				ce = (w.col_end > COLUMNS) ? COLUMNS : w.col_end;
				re = (w.row_end > ROWS) ? ROWS : w.row_end;
				for (int r = w.row; r < re; r++)
					for (int c = w.col; c < ce; c++) begin
						scr_letter[cell_index(c, r)] = SPACE_CODE;
						scr_color[cell_index(c, r)] = w.color;
					end
			end
			MODE_PUT: begin
				// Off-screen puts are dropped; on-screen ones OR only the low nibble.
				if (w.col < COLUMNS && w.row < ROWS) begin
					scr_letter[cell_index(w.col, w.row)] = w.letter;
					scr_color[cell_index(w.col, w.row)] |= {4'h0, w.color[3:0]};
				end
			end
			MODE_BLIT: begin
				// Saturate the row count at 8, then clip to the rows left below.
				if (w.col < COLUMNS && w.row < ROWS) begin
					n = (w.rows > 8) ? 8 : w.rows;
					if (n > ROWS - w.row)
						n = ROWS - w.row;
					for (int r = w.row; r < w.row + n; r++)
						scr_color[cell_index(w.col, r)] = w.bitmap_byte[r % 8] ?
							cfg_shadow.lit_color : cfg_shadow.dark_color;
				end
			end
			MODE_READ: begin
				// Off-screen reads answer as a blank cell of colour 0.
				lt = SPACE_CODE;
				cc = 8'h00;
				if (w.col < COLUMNS && w.row < ROWS) begin
					lt = scr_letter[cell_index(w.col, w.row)];
					cc = scr_color[cell_index(w.col, w.row)];
				end
				rd.shown_letter = (cc[7] && !phase_on) ? SPACE_CODE : lt;
				rd.fore = cc[3:0];
				rd.back = cc[6:4];
				rd.blinking = cc[7];
				rd.pair_index = {cc[6:4], cc[3:0]};
				pending_reads.push_back(rd);
			end
			MODE_TICK: begin
				// A period of zero behaves as one.
				period = (cfg_shadow.blink_period == 8'd0) ? 1 : cfg_shadow.blink_period;
				if (int'(tick_count) + 1 >= period) begin
					tick_count = 8'd0;
					phase_on = !phase_on;
				end else begin
					tick_count = tick_count + 8'd1;
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Read word checker and response-side stalls
	// ------------------------------------------------------------------
	function automatic void check_read_word(input read_word_t got);
		read_word_t want;
		if (pending_reads.size() == 0) begin
			$error("read word with none expected: letter %0h fore %0h back %0h",
				got.shown_letter, got.fore, got.back);
			errors++;
			return;
		end
		want = pending_reads.pop_front();
		if (got.shown_letter !== want.shown_letter) begin
			$error("shown_letter: expected %0h, got %0h", want.shown_letter, got.shown_letter);
			errors++;
		end
		if (got.fore !== want.fore) begin
			$error("fore: expected %0h, got %0h", want.fore, got.fore);
			errors++;
		end
		if (got.back !== want.back) begin
			$error("back: expected %0h, got %0h", want.back, got.back);
			errors++;
		end
		if (got.blinking !== want.blinking) begin
			$error("blinking: expected %0h, got %0h", want.blinking, got.blinking);
			errors++;
		end
		if (got.pair_index !== want.pair_index) begin
			$error("pair_index: expected %0h, got %0h", want.pair_index, got.pair_index);
			errors++;
		end
	endfunction

	// Values read right after the edge are the ones the edge sampled, since the
	// block and this bench update only through nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			check_read_word('{rsp.shown_letter, rsp.fore, rsp.back, rsp.blinking,
				rsp.pair_index});
		// Stall about one cycle in ten, never during a steady stretch.
		rsp.ready <= steady || ($urandom_range(99) >= 10);
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Offer one command word, idling first at random; predict it on acceptance.
	// Valid stays high on return, so a following word goes out back to back.
	task automatic send_word(input cmd_word_t w);
		while (!steady && $urandom_range(99) < 10) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.mode        <= w.mode;
		cmd.col         <= w.col;
		cmd.row         <= w.row;
		cmd.col_end     <= w.col_end;
		cmd.row_end     <= w.row_end;
		cmd.letter      <= w.letter;
		cmd.color       <= w.color;
		cmd.bitmap_byte <= w.bitmap_byte;
		cmd.rows        <= w.rows;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		apply_word(w);
	endtask

	// Random content in every field; each mode helper then overwrites the ones it uses.
	function automatic cmd_word_t noise_word(input logic [2:0] m);
		cmd_word_t w;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		w = raw[$bits(cmd_word_t)-1:0];
		w.mode = m;
		return w;
	endfunction

	task automatic clear_rect(input logic [6:0] c, input logic [4:0] r,
		input logic [6:0] ce, input logic [4:0] re, input logic [7:0] colr);
		cmd_word_t w;
		w = noise_word(MODE_CLEAR);
		w.col = c;
		w.row = r;
		w.col_end = ce;
		w.row_end = re;
		w.color = colr;
		send_word(w);
	endtask

	task automatic put_char(input logic [6:0] c, input logic [4:0] r,
		input logic [7:0] lt, input logic [7:0] colr);
		cmd_word_t w;
		w = noise_word(MODE_PUT);
		w.col = c;
		w.row = r;
		w.letter = lt;
		w.color = colr;
		send_word(w);
	endtask

	task automatic blit(input logic [6:0] c, input logic [4:0] r,
		input logic [7:0] pixels, input logic [3:0] n);
		cmd_word_t w;
		w = noise_word(MODE_BLIT);
		w.col = c;
		w.row = r;
		w.bitmap_byte = pixels;
		w.rows = n;
		send_word(w);
	endtask

	task automatic read_cell(input logic [6:0] c, input logic [4:0] r);
		cmd_word_t w;
		w = noise_word(MODE_READ);
		w.col = c;
		w.row = r;
		send_word(w);
	endtask

	task automatic frame_tick();
		send_word(noise_word(MODE_TICK));
	endtask

	// APB write: setup cycle, access cycle, then back to idle with psel low so that psel never
	// gets two assignments in one step across back-to-back writes.
	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'({idx, 2'b00});
		pwdata  <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_BLINK_PERIOD: cfg_shadow.blink_period = value;
			REG_LIT_COLOR:    cfg_shadow.lit_color = value;
			REG_DARK_COLOR:   cfg_shadow.dark_color = value;
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every owed read word (bounded), then let the back end settle.
	task automatic wait_idle(input int settle);
		int waited;
		waited = 0;
		cmd.valid <= 1'b0;
		while (pending_reads.size() != 0 && waited < IDLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reads.size() != 0) begin
			$error("%0d read words never arrived", pending_reads.size());
			errors += pending_reads.size();
			pending_reads.delete();
		end
		repeat (settle) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------
	task automatic test_reset_contents();
		// The clearing pass must leave blank cells everywhere; off-screen reads too.
		read_cell(7'd0, 5'd0);
		read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
		read_cell(7'd127, 5'd31);
	endtask

	task automatic test_put_char();
		put_char(7'd0, 5'd0, 8'hFF, 8'h0F);
		put_char(7'(COLUMNS - 1), 5'(ROWS - 1), 8'h00, 8'hF5);
		// Off the right edge and off the bottom: both dropped.
		put_char(7'(COLUMNS), 5'd0, 8'h41, 8'hFF);
		put_char(7'd0, 5'(ROWS), 8'h42, 8'hFF);
		read_cell(7'd0, 5'd0);
		read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
	endtask

	task automatic test_clear_rect();
		// Edges past the screen clip; blink bit set in the fill colour.
		clear_rect(7'(COLUMNS - 2), 5'(ROWS - 2), 7'd127, 5'd31, 8'hFF);
		// Inverted rectangle writes nothing.
		clear_rect(7'd10, 5'd10, 7'd5, 5'd5, 8'h12);
		put_char(7'(COLUMNS - 1), 5'(ROWS - 1), 8'h7E, 8'h01);
		read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
	endtask

	task automatic test_blit_column();
		// Count of 15 saturates to 8 and then clips to the five rows left.
		blit(7'd3, 5'(ROWS - 5), 8'hA5, 4'd15);
		// Column off screen, and a zero-row blit: no effect.
		blit(7'(COLUMNS), 5'd0, 8'hFF, 4'd8);
		blit(7'd0, 5'd0, 8'h00, 4'd0);
		read_cell(7'd3, 5'(ROWS - 1));
		read_cell(7'd3, 5'(ROWS - 5));
	endtask

	task automatic test_blink_tick();
		// Period is 1 here, so one tick turns the phase off and hides blinking cells.
		frame_tick();
		read_cell(7'(COLUMNS - 1), 5'(ROWS - 1));
	endtask

	task automatic test_unused_modes();
		send_word(noise_word(MODE_SPARE_LO));
		send_word(noise_word(MODE_SPARE_MID));
		send_word(noise_word(MODE_SPARE_HI));
	endtask

	// ------------------------------------------------------------------
	// Random traffic
	// ------------------------------------------------------------------
	// Mostly a small hot area so reads land on cells just written; some edges;
	// some anywhere in the field range so every coordinate bit toggles.
	task automatic pick_spot(output logic [6:0] c, output logic [4:0] r);
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			c = hot_col + 7'($urandom_range(0, 7));
			r = hot_row + 5'($urandom_range(0, 4));
		end else if (sel < 85) begin
			case ($urandom_range(2))
				0: c = 7'd0;
				1: c = 7'(COLUMNS - 1);
				default: c = 7'(COLUMNS);
			endcase
			case ($urandom_range(2))
				0: r = 5'd0;
				1: r = 5'(ROWS - 1);
				default: r = 5'(ROWS);
			endcase
		end else begin
			c = 7'($urandom_range(0, 127));
			r = 5'($urandom_range(0, 31));
		end
	endtask

	task automatic random_word();
		int pick;
		logic [6:0] c;
		logic [4:0] r;
		pick = $urandom_range(99);
		pick_spot(c, r);
		if (pick < 10) begin
			// Keep most rectangles small; the odd one covers the whole screen.
			if ($urandom_range(49) == 0)
				clear_rect(7'd0, 5'd0, 7'd127, 5'd31, 8'($urandom));
			else if ($urandom_range(9) == 0)
				clear_rect(c, r, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
					8'($urandom));
			else
				clear_rect(c, r, c + 7'($urandom_range(0, 8)), r + 5'($urandom_range(0, 4)),
					8'($urandom));
		end else if (pick < 35) begin
			put_char(c, r, 8'($urandom), 8'($urandom));
		end else if (pick < 50) begin
			blit(c, r, 8'($urandom), 4'($urandom_range(0, 15)));
		end else if (pick < 85) begin
			read_cell(c, r);
		end else if (pick < 97) begin
			frame_tick();
		end else begin
			send_word(noise_word(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))));
		end
	endtask

	// One setting of the registers, written while idle, then a burst of random words.
	task automatic random_phase(input logic [7:0] period, input logic [7:0] lit,
		input logic [7:0] dark, input bit calm);
		wait_idle(DRAIN_CYCLES);
		cfg_write(REG_BLINK_PERIOD, period);
		cfg_write(REG_LIT_COLOR, lit);
		cfg_write(REG_DARK_COLOR, dark);
		steady = calm;
		for (int i = 0; i < PHASE_WORDS; i++) begin
			// Move the hot area now and then so the whole screen gets traffic.
			if (i % 50 == 0) begin
				hot_col = 7'($urandom_range(0, COLUMNS - 8));
				hot_row = 5'($urandom_range(0, ROWS - 5));
			end
			random_word();
		end
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		random_phase(8'd1, 8'hFF, 8'h00, 1'b0);
		// Long stretch with no idling on either side.
		random_phase(8'd255, 8'h00, 8'hFF, 1'b1);
		random_phase(8'd0, 8'($urandom), 8'($urandom), 1'b0);
		random_phase(8'($urandom_range(2, 8)), 8'($urandom), 8'($urandom), 1'b0);
		random_phase(8'($urandom_range(1, 4)), 8'($urandom), 8'($urandom), 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		cmd.valid       <= 1'b0;
		cmd.mode        <= MODE_TICK;
		cmd.col         <= '0;
		cmd.row         <= '0;
		cmd.col_end     <= '0;
		cmd.row_end     <= '0;
		cmd.letter      <= '0;
		cmd.color       <= '0;
		cmd.bitmap_byte <= '0;
		cmd.rows        <= '0;
		errors = 0;
		steady = 1'b0;
		hot_col = 7'd0;
		hot_row = 5'd0;

		// Predictor starts where the clearing pass leaves the block.
		for (int i = 0; i < CELL_COUNT; i++) begin
			scr_letter[i] = SPACE_CODE;
			scr_color[i] = 8'h00;
		end
		tick_count = 8'd0;
		phase_on = 1'b1;
		cfg_shadow.blink_period = 8'd15;
		cfg_shadow.lit_color = 8'h70;
		cfg_shadow.dark_color = 8'h00;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers may be written during the clearing pass; cmd.ready holds off words.
		cfg_write(REG_BLINK_PERIOD, 8'd1);
		cfg_write(REG_LIT_COLOR, 8'hD3);
		cfg_write(REG_DARK_COLOR, 8'h2C);

		test_reset_contents();
		test_put_char();
		test_clear_rect();
		test_blit_column();
		test_blink_tick();
		test_unused_modes();
		test_random_traffic();

		wait_idle(DRAIN_CYCLES);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
rtl/tcb_pkg.sv
rtl/tcb_if.sv
rtl/tcb_ram.sv
rtl/tcb_front.sv
rtl/tcb_back.sv
rtl/text_cell_buffer_blitter.sv
sim/tb_top.sv
